// File: rtl/sgli_pkg.sv
// Shared types and constants for the short-gap linear interpolator.
// Used by the channel interfaces, the divider, the sequencer and the top level.
// No dependencies.
package sgli_pkg;

  // Coordinate and arithmetic widths
  localparam int COORD_W = 24;
  localparam int DIV_W   = COORD_W + 1;   // signed coordinate difference
  localparam int SUM_W   = COORD_W + 2;   // running interpolation sum
  localparam int CNT_W   = $clog2(DIV_W);  // divider step counter

  localparam int MAX_GAP_DEF = 3;

  // Kind of an emitted item
  typedef enum logic [1:0] {
    KIND_MISSING  = 2'd0,
    KIND_MEASURED = 2'd1,
    KIND_INTERP   = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_EMIT
  } state_t;

  // One input item
  typedef struct packed {
    logic                      point_present;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic                      curve_end;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    kind_t                     kind;
    logic                      run_last;
    logic                      pass_end;
  } result_t;

  // Divider request and response
  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/sgli_in_if.sv
// Input item channel: valid/ready handshake carrying one curve item.
// Depends on sgli_pkg for the coordinate width.
interface sgli_in_if;
  logic                               valid;
  logic                               ready;
  logic                               point_present;
  logic signed [sgli_pkg::COORD_W-1:0] pos_x;
  logic signed [sgli_pkg::COORD_W-1:0] pos_y;
  logic                               curve_end;

  modport source (output valid, point_present, pos_x, pos_y, curve_end, input ready);
  modport sink   (input valid, point_present, pos_x, pos_y, curve_end, output ready);
endinterface

// File: rtl/sgli_out_if.sv
// Result item channel: valid/ready handshake carrying one emitted item.
// Depends on sgli_pkg for the coordinate width.
interface sgli_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sgli_pkg::COORD_W-1:0] out_x;
  logic signed [sgli_pkg::COORD_W-1:0] out_y;
  logic [1:0]                         item_kind;
  logic                               run_last;
  logic                               pass_end;

  modport source (output valid, out_x, out_y, item_kind, run_last, pass_end, input ready);
  modport sink   (input valid, out_x, out_y, item_kind, run_last, pass_end, output ready);
endinterface

// File: rtl/sgli_div.sv
// Bit-serial restoring divider: signed difference by a small positive divisor,
// floor quotient and non-negative remainder. One quotient bit per cycle.
// Depends on sgli_pkg.
module sgli_div #(
  parameter int DEN_W = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sgli_pkg::div_req_t       req,
  input  logic [DEN_W-1:0]         den,
  output sgli_pkg::div_rsp_t       rsp,
  output logic [DEN_W-1:0]         rem
);

  localparam int DW = sgli_pkg::DIV_W;
  localparam int CW = sgli_pkg::CNT_W;

  logic              busy_r, busy_nxt;
  logic              fin_r, fin_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DW-1:0]     num_r, num_nxt;
  logic [DW-1:0]     quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic              neg_r, neg_nxt;

  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;
  logic [DW-1:0]     mag;

  // One restoring step and the load of a new division
  always_comb begin
    trial    = {rem_r, num_r[DW-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    mag      = req.dividend[DW-1] ? DW'(-req.dividend) : DW'(req.dividend);
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = mag;
      quo_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
      neg_nxt  = req.dividend[DW-1];
    end else if (busy_r) begin
      num_nxt = {num_r[DW-2:0], 1'b0};
      quo_nxt = {quo_r[DW-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // Sign fix-up to floor semantics
  always_comb begin
    rsp.done = fin_r;
    if (neg_r && (rem_r != '0)) begin
      rsp.quotient = $signed(~quo_r);
      rem          = den_r - rem_r;
    end else if (neg_r) begin
      rsp.quotient = $signed(-quo_r);
      rem          = rem_r;
    end else begin
      rsp.quotient = $signed(quo_r);
      rem          = rem_r;
    end
  end

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < den_r)
    else $error("partial remainder not below divisor");
  a_fin_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> $past(busy_r))
    else $error("divider finished without running");

endmodule

// File: rtl/sgli_ctrl.sv
// Sequencer: keeps the anchor and the held gap, drives the shared divider and
// steps the interpolation one result per cycle while taken. Depends on sgli_pkg, sgli_div.
module sgli_ctrl #(
  parameter int MAX_GAP = sgli_pkg::MAX_GAP_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sgli_pkg::in_item_t   in_item,
  output logic                 res_valid,
  input  logic                 res_take,
  output sgli_pkg::result_t    res
);

  localparam int GAP_W = $clog2(MAX_GAP + 1);
  localparam int DEN_W = $clog2(MAX_GAP + 2);
  localparam int CW    = sgli_pkg::COORD_W;
  localparam int DW    = sgli_pkg::DIV_W;
  localparam int SW    = sgli_pkg::SUM_W;

  sgli_pkg::state_t state_r, state_nxt;
  logic signed [CW-1:0] anchor_x_r, anchor_x_nxt, anchor_y_r, anchor_y_nxt;
  logic                 anchor_valid_r, anchor_valid_nxt;
  logic [GAP_W-1:0]     held_r, held_nxt;
  logic                 ovf_r, ovf_nxt;
  logic signed [CW-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [CW-1:0] fin_x_r, fin_x_nxt, fin_y_r, fin_y_nxt;
  logic signed [DW-1:0] dy_r, dy_nxt;
  logic signed [DW-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic [DEN_W-1:0]     rx_r, rx_nxt, ry_r, ry_nxt;
  logic [DEN_W-1:0]     racc_x_r, racc_x_nxt, racc_y_r, racc_y_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [GAP_W-1:0]     pre_left_r, pre_left_nxt;
  sgli_pkg::kind_t      pre_kind_r, pre_kind_nxt, fin_kind_r, fin_kind_nxt;
  logic                 last_r, last_nxt;

  sgli_pkg::div_req_t   div_req;
  sgli_pkg::div_rsp_t   div_rsp;
  logic [DEN_W-1:0]     div_rem;

  logic [DEN_W:0]       rsum_x, rsum_y;
  logic                 cy_x, cy_y;
  logic [SW-1:0]        sum_x, sum_y;
  logic signed [DW-1:0] dx_in, dy_in;
  logic                 accept;

  // divisor taken from the next value so a start on accept sees the new gap
  sgli_div #(.DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .den   (den_nxt),
    .rsp   (div_rsp),
    .rem   (div_rem)
  );

  // Next interpolated point: add the step quotient and a carry from the remainder
  always_comb begin
    rsum_x = {1'b0, racc_x_r} + {1'b0, rx_r};
    rsum_y = {1'b0, racc_y_r} + {1'b0, ry_r};
    cy_x   = (rsum_x >= {1'b0, den_r});
    cy_y   = (rsum_y >= {1'b0, den_r});
    sum_x  = {{2{cur_x_r[CW-1]}}, cur_x_r} + {qx_r[DW-1], qx_r} + SW'(cy_x);
    sum_y  = {{2{cur_y_r[CW-1]}}, cur_y_r} + {qy_r[DW-1], qy_r} + SW'(cy_y);
    dx_in  = {in_item.pos_x[CW-1], in_item.pos_x} - {anchor_x_r[CW-1], anchor_x_r};
    dy_in  = {in_item.pos_y[CW-1], in_item.pos_y} - {anchor_y_r[CW-1], anchor_y_r};
  end

  // Next state and outputs
  always_comb begin
    state_nxt        = state_r;
    anchor_x_nxt     = anchor_x_r;
    anchor_y_nxt     = anchor_y_r;
    anchor_valid_nxt = anchor_valid_r;
    held_nxt         = held_r;
    ovf_nxt          = ovf_r;
    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    fin_x_nxt        = fin_x_r;
    fin_y_nxt        = fin_y_r;
    dy_nxt           = dy_r;
    qx_nxt           = qx_r;
    qy_nxt           = qy_r;
    rx_nxt           = rx_r;
    ry_nxt           = ry_r;
    racc_x_nxt       = racc_x_r;
    racc_y_nxt       = racc_y_r;
    den_nxt          = den_r;
    pre_left_nxt     = pre_left_r;
    pre_kind_nxt     = pre_kind_r;
    fin_kind_nxt     = fin_kind_r;
    last_nxt         = last_r;
    div_req.start    = 1'b0;
    div_req.dividend = dx_in;
    in_ready         = 1'b0;
    res_valid        = 1'b0;
    res.x            = '0;
    res.y            = '0;
    res.kind         = fin_kind_r;
    res.run_last     = 1'b0;
    res.pass_end     = 1'b0;
    accept           = 1'b0;

    case (state_r)
      sgli_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (accept) begin
          last_nxt     = in_item.curve_end;
          cur_x_nxt    = anchor_x_r;
          cur_y_nxt    = anchor_y_r;
          racc_x_nxt   = '0;
          racc_y_nxt   = '0;
          den_nxt      = DEN_W'(held_r) + DEN_W'(1'b1);
          fin_x_nxt    = '0;
          fin_y_nxt    = '0;
          pre_left_nxt = '0;
          fin_kind_nxt = sgli_pkg::KIND_MISSING;
          if (in_item.point_present) begin
            // Present point: fill the held run, then the point itself
            pre_left_nxt     = held_r;
            pre_kind_nxt     = sgli_pkg::KIND_INTERP;
            fin_kind_nxt     = sgli_pkg::KIND_MEASURED;
            fin_x_nxt        = in_item.pos_x;
            fin_y_nxt        = in_item.pos_y;
            anchor_x_nxt     = in_item.pos_x;
            anchor_y_nxt     = in_item.pos_y;
            anchor_valid_nxt = 1'b1;
            held_nxt         = '0;
            ovf_nxt          = 1'b0;
            dy_nxt           = dy_in;
            if (held_r != '0) begin
              div_req.start = 1'b1;
              state_nxt     = sgli_pkg::ST_DIV_X;
            end else begin
              state_nxt = sgli_pkg::ST_EMIT;
            end
          end else if (!anchor_valid_r || ovf_r) begin
            // No anchor, or run already too long: pass straight through
            state_nxt = sgli_pkg::ST_EMIT;
          end else if (in_item.curve_end || (held_r >= GAP_W'(MAX_GAP))) begin
            // Flush the held run as missing
            pre_left_nxt = held_r;
            pre_kind_nxt = sgli_pkg::KIND_MISSING;
            held_nxt     = '0;
            ovf_nxt      = 1'b1;
            state_nxt    = sgli_pkg::ST_EMIT;
          end else begin
            held_nxt = held_r + GAP_W'(1);
          end
          if (in_item.curve_end) begin
            anchor_x_nxt     = '0;
            anchor_y_nxt     = '0;
            anchor_valid_nxt = 1'b0;
            held_nxt         = '0;
            ovf_nxt          = 1'b0;
          end
        end
      end
      sgli_pkg::ST_DIV_X: begin
        if (div_rsp.done) begin
          qx_nxt           = div_rsp.quotient;
          rx_nxt           = div_rem;
          div_req.start    = 1'b1;
          div_req.dividend = dy_r;
          state_nxt        = sgli_pkg::ST_DIV_Y;
        end
      end
      sgli_pkg::ST_DIV_Y: begin
        if (div_rsp.done) begin
          qy_nxt    = div_rsp.quotient;
          ry_nxt    = div_rem;
          state_nxt = sgli_pkg::ST_EMIT;
        end
      end
      sgli_pkg::ST_EMIT: begin
        res_valid = 1'b1;
        if (pre_left_r != '0) begin
          res.kind = pre_kind_r;
          if (pre_kind_r == sgli_pkg::KIND_INTERP) begin
            res.x = sum_x[CW-1:0];
            res.y = sum_y[CW-1:0];
          end
          if (res_take) begin
            pre_left_nxt = pre_left_r - GAP_W'(1);
            cur_x_nxt    = sum_x[CW-1:0];
            cur_y_nxt    = sum_y[CW-1:0];
            racc_x_nxt   = cy_x ? DEN_W'(rsum_x - {1'b0, den_r}) : rsum_x[DEN_W-1:0];
            racc_y_nxt   = cy_y ? DEN_W'(rsum_y - {1'b0, den_r}) : rsum_y[DEN_W-1:0];
          end
        end else begin
          res.kind     = fin_kind_r;
          res.x        = fin_x_r;
          res.y        = fin_y_r;
          res.run_last = 1'b1;
          res.pass_end = last_r;
          if (res_take) begin
            state_nxt = sgli_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sgli_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= sgli_pkg::ST_IDLE;
      anchor_x_r     <= '0;
      anchor_y_r     <= '0;
      anchor_valid_r <= 1'b0;
      held_r         <= '0;
      ovf_r          <= 1'b0;
      pre_left_r     <= '0;
    end else begin
      state_r        <= state_nxt;
      anchor_x_r     <= anchor_x_nxt;
      anchor_y_r     <= anchor_y_nxt;
      anchor_valid_r <= anchor_valid_nxt;
      held_r         <= held_nxt;
      ovf_r          <= ovf_nxt;
      pre_left_r     <= pre_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    fin_x_r    <= fin_x_nxt;
    fin_y_r    <= fin_y_nxt;
    dy_r       <= dy_nxt;
    qx_r       <= qx_nxt;
    qy_r       <= qy_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    racc_x_r   <= racc_x_nxt;
    racc_y_r   <= racc_y_nxt;
    den_r      <= den_nxt;
    pre_kind_r <= pre_kind_nxt;
    fin_kind_r <= fin_kind_nxt;
    last_r     <= last_nxt;
  end

  a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= GAP_W'(MAX_GAP))
    else $error("held gap count above limit");
  a_ovf_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    !(ovf_r && (held_r != '0)))
    else $error("overflow flagged while items are held");
  a_racc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sgli_pkg::ST_EMIT && pre_left_r != '0 && pre_kind_r == sgli_pkg::KIND_INTERP)
      |-> (racc_x_r < den_r) && (racc_y_r < den_r))
    else $error("interpolation remainder out of range");
  a_curve_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.curve_end) |=> !anchor_valid_r && (held_r == '0) && !ovf_r)
    else $error("curve end did not clear the gap state");

endmodule

// File: rtl/short_gap_linear_interpolator_top.sv
// Sequence: a present point ending a gap of n items is accepted, then divided
// twice on the shared bit-serial divider (x then y), then gives n+1 results at
// one per cycle while the output takes them; other items skip the divider.
// Throughput: one item at a time; the next is taken once the last result is
// in the output register. Reset: synchronous, clears all control state.
module short_gap_linear_interpolator_top #(
  parameter int MAX_GAP = sgli_pkg::MAX_GAP_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sgli_in_if.sink    in_items,
  sgli_out_if.source out_items
);

  sgli_pkg::in_item_t in_item;
  sgli_pkg::result_t  res;
  sgli_pkg::result_t  out_r;
  logic               res_valid;
  logic               res_take;
  logic               out_valid_r, out_valid_nxt;
  logic               in_ready;

  // Pack the input channel
  always_comb begin
    in_item.point_present = in_items.point_present;
    in_item.pos_x         = in_items.pos_x;
    in_item.pos_y         = in_items.pos_y;
    in_item.curve_end     = in_items.curve_end;
  end

  assign in_items.ready = in_ready;

  sgli_ctrl #(.MAX_GAP(MAX_GAP)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_items.valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register: loads a new item whenever it is empty or being drained
  always_comb begin
    res_take      = res_valid && (!out_valid_r || out_items.ready);
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_items.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_items.valid     = out_valid_r;
  assign out_items.out_x     = out_r.x;
  assign out_items.out_y     = out_r.y;
  assign out_items.item_kind = out_r.kind;
  assign out_items.run_last  = out_r.run_last;
  assign out_items.pass_end  = out_r.pass_end;

  a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == sgli_pkg::KIND_MISSING) |-> (out_r.x == '0) && (out_r.y == '0))
    else $error("missing item carries coordinates");
  a_pass_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.pass_end) |-> out_r.run_last)
    else $error("pass end on an item that is not the last of its run");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_items.valid && in_ready) |=> !in_ready || !res_valid)
    else $error("sequencer ready while results pending");

endmodule
